// File: design/rc4_stream_cipher_defines.svh
// Assertion macros for the RC4 cipher top level.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication on clk, disabled in reset.
`define RC4_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, disabled in reset.
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rc4_pkg.sv
// Types and constants shared by the RC4 cipher modules.
`timescale 1ns / 1ps
`default_nettype none
package rc4_pkg;

	localparam int PERM_SIZE = 256;
	localparam int KEY_DEPTH_DEF = 256;
	localparam logic [8:0] KEY_LENGTH_RST = 9'd16;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_SCHED = 2'd1,
		CMD_CRYPT = 2'd2
	} cmd_t;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_INIT = 11'b000_0000_0010,
		ST_K0   = 11'b000_0000_0100,
		ST_K1   = 11'b000_0000_1000,
		ST_K2   = 11'b000_0001_0000,
		ST_K3   = 11'b000_0010_0000,
		ST_C1   = 11'b000_0100_0000,
		ST_C2   = 11'b000_1000_0000,
		ST_C3   = 11'b001_0000_0000,
		ST_HOLD = 11'b010_0000_0000,
		ST_SPARE = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic [7:0] keystream_byte;
		logic [7:0] cipher_byte;
	} res_t;

	typedef struct packed {
		logic busy;
		logic keyed;
	} core_stat_t;

endpackage
`default_nettype wire

// File: design/rc4_stream_cipher.sv
// RC4 stream cipher top level: key length register, sequencer, output register.
// Crypt: states C1, C2, C3, then the output register (perm RAM read is registered).
// Schedule: 256 identity writes, then states K0, K1, K2, K3 for each permutation entry.
// One command at a time; a finished crypt result waits in the output register.
// arst_n clears indices, keyed flag, handshake state; key_length resets to 16.
// Permutation and key RAM contents are undefined until written.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_defines.svh"
`default_nettype none
module rc4_stream_cipher #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // key_position, data_byte
	input  logic [1:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // cipher_byte, keystream_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	import rc4_pkg::*;

	logic [8:0] key_length_q;
	logic m_tvalid_q;
	res_t m_res_q;
	logic res_valid, res_ready;
	res_t res;
	core_stat_t core_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KEY_LENGTH_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_length_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {m_res_q.keystream_byte, m_res_q.cipher_byte};

	rc4_core #(.KEY_DEPTH(KEY_DEPTH)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (cmd_t'(s_tuser)),
		.in_pos     (s_tdata[7:0]),
		.in_data    (s_tdata[15:8]),
		.key_length (key_length_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.stat       (core_stat)
	);

	`RC4_ASSERT_IMPL(a_res_keyed, res_valid, core_stat.keyed, "crypt result without schedule")
	`RC4_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid && $stable(res), "pending result lost")
	`RC4_ASSERT_NEXT(a_crypt_busy, s_tvalid && s_tready && (s_tuser == CMD_CRYPT) && core_stat.keyed, core_stat.busy && !s_tready, "keyed crypt did not start")
	`RC4_ASSERT_IMPL(a_idle_ready, !core_stat.busy, s_tready, "idle core not ready")

endmodule
`default_nettype wire

// File: design/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: design/rc4_core.sv
// RC4 sequencer: key schedule and keystream steps over one shared 8-bit adder.
`timescale 1ns / 1ps
`default_nettype none
module rc4_core #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rc4_pkg::cmd_t       in_cmd,
	input  logic [7:0]          in_pos,
	input  logic [7:0]          in_data,
	input  logic [8:0]          key_length,
	output logic                res_valid,
	input  logic                res_ready,
	output rc4_pkg::res_t       res,
	output rc4_pkg::core_stat_t stat
);
	import rc4_pkg::*;

	localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam logic [8:0] KeyDepthW = 9'(KEY_DEPTH);

	state_t state_q;
	logic [7:0] n_q, i_q, j_q;
	logic [KW-1:0] kidx_q, klast_q;
	logic keyed_q;
	logic [7:0] si_q, sj_q, data_q, ks_q;
	logic hit_i_q, hit_j_q;

	logic [7:0] add_a, add_b, add_c, sum;
	logic p_we;
	logic [7:0] p_waddr, p_wdata, p_raddr, perm_rd;
	logic k_we;
	logic [7:0] key_rd;
	logic [8:0] klast_c;
	logic [7:0] ks_c;
	logic accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// shared adder
	always_comb begin
		add_a = i_q;
		add_b = 8'd0;
		add_c = 8'd0;
		unique case (state_q)
			ST_IDLE: begin
				add_c = 8'd1;
			end
			ST_K1: begin
				add_a = j_q;
				add_b = perm_rd;
				add_c = key_rd;
			end
			ST_C1: begin
				add_a = j_q;
				add_b = perm_rd;
			end
			ST_C2: begin
				add_a = si_q;
				add_b = perm_rd;
			end
			default: ;
		endcase
		sum = add_a + add_b + add_c;
	end

	// permutation port control
	always_comb begin
		p_we = 1'b0;
		p_waddr = n_q;
		p_wdata = n_q;
		p_raddr = n_q;
		unique case (state_q)
			ST_IDLE: p_raddr = sum;
			ST_INIT: p_we = 1'b1;
			ST_K1:   p_raddr = sum;
			ST_K2: begin
				p_we = 1'b1;
				p_wdata = perm_rd;
			end
			ST_K3, ST_C3: begin
				p_we = 1'b1;
				p_waddr = j_q;
				p_wdata = si_q;
			end
			ST_C1: p_raddr = sum;
			ST_C2: begin
				p_we = 1'b1;
				p_waddr = i_q;
				p_wdata = perm_rd;
				p_raddr = sum;
			end
			default: ;
		endcase
	end

	assign k_we = accept && (in_cmd == CMD_LOAD) && ({1'b0, in_pos} < KeyDepthW);

	always_comb begin
		if (key_length == 9'd0) begin
			klast_c = 9'd0;
		end else if (key_length > KeyDepthW) begin
			klast_c = KeyDepthW - 9'd1;
		end else begin
			klast_c = key_length - 9'd1;
		end
	end

	// keystream byte after the swap
	always_comb begin
		if (hit_j_q) begin
			ks_c = si_q;
		end else if (hit_i_q) begin
			ks_c = sj_q;
		end else begin
			ks_c = perm_rd;
		end
	end

	rc4_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_perm (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (perm_rd)
	);

	rc4_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key (
		.clk   (clk),
		.we    (k_we),
		.waddr (in_pos[KW-1:0]),
		.wdata (in_data),
		.raddr (kidx_q),
		.rdata (key_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= 8'd0;
			i_q <= 8'd0;
			j_q <= 8'd0;
			kidx_q <= '0;
			keyed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_SCHED: begin
								state_q <= ST_INIT;
								n_q <= 8'd0;
								kidx_q <= '0;
								j_q <= 8'd0;
							end
							CMD_CRYPT: begin
								if (keyed_q) begin
									i_q <= sum;
									state_q <= ST_C1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						state_q <= ST_K0;
					end
				end
				ST_K0: state_q <= ST_K1;
				ST_K1: begin
					j_q <= sum;
					state_q <= ST_K2;
				end
				ST_K2: state_q <= ST_K3;
				ST_K3: begin
					n_q <= n_q + 8'd1;
					kidx_q <= (kidx_q == klast_q) ? '0 : kidx_q + KW'(1);
					if (n_q == 8'hFF) begin
						state_q <= ST_IDLE;
						keyed_q <= 1'b1;
						i_q <= 8'd0;
						j_q <= 8'd0;
					end else begin
						state_q <= ST_K0;
					end
				end
				ST_C1: begin
					j_q <= sum;
					state_q <= ST_C2;
				end
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= res_ready ? ST_IDLE : ST_HOLD;
				ST_HOLD: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			data_q <= in_data;
			klast_q <= klast_c[KW-1:0];
		end
		if (state_q == ST_K1 || state_q == ST_C1) begin
			si_q <= perm_rd;
		end
		if (state_q == ST_C2) begin
			sj_q <= perm_rd;
			hit_i_q <= (sum == i_q);
			hit_j_q <= (sum == j_q);
		end
		if (state_q == ST_C3) begin
			ks_q <= ks_c;
		end
	end

	assign res_valid = (state_q == ST_C3) || (state_q == ST_HOLD);
	assign res.keystream_byte = (state_q == ST_C3) ? ks_c : ks_q;
	assign res.cipher_byte = data_q ^ res.keystream_byte;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.keyed = keyed_q;

endmodule
`default_nettype wire

// File: verif/rc4_stream_checker.sv
// Checker for the RC4 stream cipher: tracks cipher state and checks every result transfer.
`timescale 1ns / 1ps
module rc4_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // key_position, data_byte
	input  logic [1:0]  s_tuser,   // command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // cipher_byte, keystream_byte
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	output int          errors,
	output int          pending
);
	import rc4_pkg::*;

	logic [7:0] sbox [PERM_SIZE];
	logic [7:0] key_mem [KEY_DEPTH_DEF];
	logic [7:0] idx_i, idx_j;
	logic       keyed;
	logic [8:0] key_len;
	res_t       exp_results [$];
	int         mism;

	// Identity fill, then the key schedule over the key bytes used cyclically.
	function automatic void rekey();
		int         len;
		logic [7:0] jj, t;
		if (key_len == 0) begin
			len = 1;
		end else if (key_len > KEY_DEPTH_DEF) begin
			len = KEY_DEPTH_DEF;
		end else begin
			len = int'(key_len);
		end
		for (int n = 0; n < PERM_SIZE; n++)
			sbox[n] = 8'(n);
		jj = 8'd0;
		for (int n = 0; n < PERM_SIZE; n++) begin
			jj = 8'(jj + sbox[n] + key_mem[n % len]);
			t = sbox[n];
			sbox[n] = sbox[jj];
			sbox[jj] = t;
		end
		idx_i = 8'd0;
		idx_j = 8'd0;
		keyed = 1'b1;
	endfunction

	function automatic void crypt_byte(input logic [7:0] dat);
		logic [7:0] ni, nj, t, ks;
		res_t       r;
		if (!keyed)
			return;
		ni = 8'(idx_i + 8'd1);
		nj = 8'(idx_j + sbox[ni]);
		t = sbox[ni];
		sbox[ni] = sbox[nj];
		sbox[nj] = t;
		ks = sbox[8'(sbox[ni] + sbox[nj])];
		idx_i = ni;
		idx_j = nj;
		r.cipher_byte = dat ^ ks;
		r.keystream_byte = ks;
		exp_results = {exp_results, r};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			keyed = 1'b0;
			idx_i = 8'd0;
			idx_j = 8'd0;
			key_len = KEY_LENGTH_RST;
			exp_results.delete();
			mism = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (exp_results.size() == 0) begin
					if (mism < 10)
						$display("%0t: unexpected result: cipher_byte %02h keystream_byte %02h",
							$time, got.cipher_byte, got.keystream_byte);
					mism++;
				end else begin
					want = exp_results.pop_front();
					if (got.cipher_byte !== want.cipher_byte ||
							got.keystream_byte !== want.keystream_byte) begin
						if (mism < 10)
							$display("%0t: mismatch: cipher_byte exp %02h got %02h, keystream_byte exp %02h got %02h",
								$time, want.cipher_byte, got.cipher_byte,
								want.keystream_byte, got.keystream_byte);
						mism++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				key_len = cfg_data;
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_LOAD:  key_mem[s_tdata[7:0]] = s_tdata[15:8];
					CMD_SCHED: rekey();
					CMD_CRYPT: crypt_byte(s_tdata[15:8]);
					default: ;
				endcase
			end
			errors <= mism;
			pending <= exp_results.size();
		end
	end

endmodule

// File: verif/rc4_stream_cipher_tb.sv
// Testbench top for the RC4 stream cipher: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module rc4_stream_cipher_tb;
	import rc4_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SCHED_CYCLES = 1280;
	localparam int SEG_ITEMS = 205;
	localparam int NUM_SEGS = 6;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // key_position, data_byte
	logic [1:0]  s_tuser = '0;     // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // cipher_byte, keystream_byte
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;
	int          errors;
	int          pending;
	int          src_idle = 0;
	int          snk_idle = 0;
	int          n_items = 0;
	int          eff = 16;
	bit          key_set [PERM_SIZE];

	rc4_stream_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	rc4_stream_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= snk_idle);

	function automatic bit key_ready(input int len);
		for (int p = 0; p < len; p++)
			if (!key_set[p])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic send(input logic [1:0] cmd, input logic [7:0] pos, input logic [7:0] dat);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {dat, pos};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_LOAD)
			key_set[pos] = 1'b1;
		if (cmd != CMD_UNUSED)
			n_items++;
	endtask

	// Hold off input until every result is back, then let a schedule run out.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SCHED_CYCLES + 32) @(posedge clk);
	endtask

	task automatic write_key_len(input logic [8:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (v == 0) begin
			eff = 1;
		end else if (v > KEY_DEPTH_DEF) begin
			eff = KEY_DEPTH_DEF;
		end else begin
			eff = int'(v);
		end
	endtask

	initial begin
		logic [8:0] lens [NUM_SEGS];
		logic [1:0] cmd;
		int         roll, seg_end;
		lens = '{9'd1, 9'd256, 9'd511, 9'($urandom_range(2, 255)), KEY_LENGTH_RST,
			9'($urandom_range(257, 510))};
		src_idle = 36;
		snk_idle = 78;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero length, unkeyed crypt, unused command, rekey while keyed
		write_key_len(9'd0);
		send(CMD_CRYPT, 8'hFF, 8'hFF);
		send(CMD_UNUSED, 8'hFF, 8'hFF);
		send(CMD_LOAD, 8'h00, 8'hFF);
		send(CMD_LOAD, 8'hFF, 8'h00);
		send(CMD_SCHED, 8'h00, 8'h00);
		send(CMD_CRYPT, 8'h00, 8'h00);
		send(CMD_CRYPT, 8'hFF, 8'hFF);
		send(CMD_UNUSED, 8'h00, 8'h00);
		send(CMD_CRYPT, 8'h00, 8'h5A);
		send(CMD_LOAD, 8'h00, 8'h00);
		send(CMD_SCHED, 8'hFF, 8'hFF);
		send(CMD_CRYPT, 8'h00, 8'hFF);
		send(CMD_CRYPT, 8'h00, 8'h00);
		send(CMD_CRYPT, 8'h00, 8'hA5);
		send(CMD_CRYPT, 8'h00, 8'h3C);
		send(CMD_LOAD, 8'h80, 8'h80);
		send(CMD_LOAD, 8'h7F, 8'h7F);

		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg == 2) begin
				src_idle = 78;
				snk_idle = 36;
			end
			if (seg == 4) begin
				src_idle = 0;
				snk_idle = 0;
			end
			drain();
			write_key_len(lens[seg]);
			seg_end = n_items + SEG_ITEMS;
			while (n_items < seg_end) begin
				roll = $urandom_range(0, 99);
				if (roll < 75) begin
					// full session: (re)load key, schedule, stream of bytes
					for (int p = 0; p < eff; p++)
						if (!key_set[p] || $urandom_range(0, eff - 1) < 4)
							send(CMD_LOAD, 8'(p), 8'($urandom));
					send(CMD_SCHED, 8'($urandom), 8'($urandom));
					repeat ($urandom_range(5, 60))
						send(CMD_CRYPT, 8'($urandom), 8'($urandom));
				end else if (roll < 88) begin
					// key bytes changed without a schedule, stream continues
					repeat ($urandom_range(1, 4))
						send(CMD_LOAD, 8'($urandom), 8'($urandom));
					repeat ($urandom_range(1, 10))
						send(CMD_CRYPT, 8'($urandom), 8'($urandom));
				end else begin
					cmd = 2'($urandom);
					if (cmd == CMD_SCHED && !key_ready(eff))
						cmd = CMD_LOAD;
					send(cmd, 8'($urandom), 8'($urandom));
				end
			end
		end

		drain();
		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
